@@ hw/rtl/binary_min_heap_queue_assert.svh @@
// Assertion macros for the binary min-heap queue
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// check a property on every clock edge outside reset
`define BMHQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define BMHQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BMHQ_ASSERT(lbl, prop, msg)

`define BMHQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/bmhq_pkg.sv @@
// Shared types and codes for the binary min-heap queue
package bmhq_pkg;

    localparam int PRIO_W  = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    typedef logic [1:0]        status_t;
    typedef logic [PRIO_W-1:0] prio_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

endpackage

@@ hw/rtl/bmhq_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module bmhq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/binary_min_heap_queue.sv @@
// Binary min-heap priority queue: sequencer, shared comparator and entry RAM
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+-----------------------------------------------
//  request | req_valid | req_stall | req_type, priority_req, payload
//  result  | rsp_valid | rsp_stall | popped_payload, popped_priority, status,
//          |           |           | entry_count, is_empty
//
// Push: per level climbed, a parent read (S_UP_CHK) then a compare (S_UP_CMP).
// Pop: per level sunk, up to two child reads and two compares through the one
// comparator; the single RAM read port sets the pace.
// A push on a full heap or a pop on an empty one goes straight to the result state.
// Reset empties the heap at once; the RAM is not cleared.
// A new request is taken while the previous result is still stalled; the
// sequencer then holds its finished result until the output register frees.
`include "binary_min_heap_queue_assert.svh"

module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY     = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      req_type,
    input  logic signed [PRIO_W-1:0]  priority_req,
    input  logic [DATA_W-1:0]         payload,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [DATA_W-1:0]         popped_payload,
    output logic signed [PRIO_W-1:0]  popped_priority,
    output status_t                   status,
    output logic [COUNT_W-1:0]        entry_count,
    output logic                      is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = PRIO_W + PAYLOAD_BITS;
    localparam int LW = AW + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_CHK  = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_DN_ROOT = 4'd3;
    localparam logic [3:0] S_DN_LAST = 4'd4;
    localparam logic [3:0] S_DN_CHK  = 4'd5;
    localparam logic [3:0] S_DN_LT   = 4'd6;
    localparam logic [3:0] S_DN_RT   = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;
    localparam logic [3:0] S_FIN     = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           kid_idx_reg, kid_idx_next;
    prio_t                   cur_prio_reg, cur_prio_next;
    logic [PAYLOAD_BITS-1:0] cur_data_reg, cur_data_next;
    prio_t                   kid_prio_reg, kid_prio_next;
    logic [PAYLOAD_BITS-1:0] kid_data_reg, kid_data_next;
    prio_t                   res_prio_reg, res_prio_next;
    logic [PAYLOAD_BITS-1:0] res_data_reg, res_data_next;
    status_t                 res_status_reg, res_status_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    prio_t                   out_prio_reg, out_prio_next;
    logic [DATA_W-1:0]       out_data_reg, out_data_next;
    status_t                 out_status_reg, out_status_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;
    logic                    out_empty_reg, out_empty_next;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [EW-1:0]           wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [EW-1:0]           rd_data;
    prio_t                   rd_prio;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    logic signed [PRIO_W-1:0] cmp_a, cmp_b;
    logic                     cmp_le;

    logic [LW-1:0] lt_w, rt_w, fill_w;
    logic          lt_ok, rt_ok;
    logic [AW-1:0] pos_dec, parent_idx;
    logic          full, out_free;

    assign rd_prio = rd_data[EW-1 -: PRIO_W];
    assign rd_pay  = rd_data[PAYLOAD_BITS-1:0];

    assign cmp_le = cmp_a <= cmp_b;

    assign lt_w       = {1'b0, pos_reg, 1'b1};
    assign rt_w       = lt_w + LW'(1);
    assign fill_w     = LW'(fill_reg);
    assign lt_ok      = lt_w < fill_w;
    assign rt_ok      = rt_w < fill_w;
    assign pos_dec    = pos_reg - AW'(1);
    assign parent_idx = pos_dec >> 1;
    assign full       = fill_reg == CW'(CAPACITY);
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        kid_idx_next    = kid_idx_reg;
        cur_prio_next   = cur_prio_reg;
        cur_data_next   = cur_data_reg;
        kid_prio_next   = kid_prio_reg;
        kid_data_next   = kid_data_reg;
        res_prio_next   = res_prio_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        out_prio_next   = out_prio_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = {cur_prio_reg, cur_data_reg};
        rd_en           = 1'b0;
        rd_addr         = lt_w[AW-1:0];
        cmp_a           = kid_prio_reg;
        cmp_b           = cur_prio_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_prio_next   = '0;
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    if (req_type == REQ_PUSH)
                    begin
                        if (full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cur_prio_next = priority_req;
                            cur_data_next = payload[PAYLOAD_BITS-1:0];
                            pos_next      = fill_reg[AW-1:0];
                            fill_next     = fill_reg + CW'(1);
                            state_next    = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            fill_next  = fill_reg - CW'(1);
                            state_next = S_DN_ROOT;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                cmp_a = rd_prio;
                cmp_b = cur_prio_reg;
                wr_en = 1'b1;
                if (!cmp_le)
                begin
                    wr_data    = rd_data;
                    pos_next   = parent_idx;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_ROOT:
            begin
                res_prio_next = rd_prio;
                res_data_next = rd_pay;
                if (fill_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = fill_reg[AW-1:0];
                    state_next = S_DN_LAST;
                end
            end
            S_DN_LAST:
            begin
                cur_prio_next = rd_prio;
                cur_data_next = rd_pay;
                pos_next      = '0;
                state_next    = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (!lt_ok)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lt_w[AW-1:0];
                    state_next = S_DN_LT;
                end
            end
            S_DN_LT:
            begin
                kid_prio_next = rd_prio;
                kid_data_next = rd_pay;
                kid_idx_next  = lt_w[AW-1:0];
                if (rt_ok)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rt_w[AW-1:0];
                    state_next = S_DN_RT;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_RT:
            begin
                cmp_a = rd_prio;
                cmp_b = kid_prio_reg;
                if (cmp_le)
                begin
                    kid_prio_next = rd_prio;
                    kid_data_next = rd_pay;
                    kid_idx_next  = rt_w[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmp_a = kid_prio_reg;
                cmp_b = cur_prio_reg;
                wr_en = 1'b1;
                if (cmp_le)
                begin
                    wr_data    = {kid_prio_reg, kid_data_reg};
                    pos_next   = kid_idx_reg;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    out_prio_next   = res_prio_reg;
                    out_data_next   = DATA_W'(res_data_reg);
                    out_status_next = res_status_reg;
                    out_count_next  = COUNT_W'(fill_reg);
                    out_empty_next  = fill_reg == '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        kid_idx_reg    <= kid_idx_next;
        cur_prio_reg   <= cur_prio_next;
        cur_data_reg   <= cur_data_next;
        kid_prio_reg   <= kid_prio_next;
        kid_data_reg   <= kid_data_next;
        res_prio_reg   <= res_prio_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_prio_reg   <= out_prio_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    bmhq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_stall       = state_reg != S_IDLE;
    assign rsp_valid       = rsp_valid_reg;
    assign popped_payload  = out_data_reg;
    assign popped_priority = out_prio_reg;
    assign status          = out_status_reg;
    assign entry_count     = out_count_reg;
    assign is_empty        = out_empty_reg;

    `BMHQ_ASSERT_ALWAYS(a_fill_max, !rst_n || fill_reg <= CW'(CAPACITY),
                        "fill count above capacity")
    `BMHQ_ASSERT(a_push_grows,
                 req_valid && !req_stall && req_type == REQ_PUSH && !full
                 |=> fill_reg == $past(fill_reg) + CW'(1),
                 "accepted push did not add an entry")
    `BMHQ_ASSERT(a_wr_in_heap, wr_en |-> CW'(wr_addr) < fill_reg,
                 "write outside the live heap")
    `BMHQ_ASSERT(a_fail_zero,
                 rsp_valid && status != ST_OK |-> popped_payload == '0 && popped_priority == '0,
                 "failed request returned an entry")
    `BMHQ_ASSERT(a_empty_flag, rsp_valid && status == ST_EMPTY |-> is_empty,
                 "empty pop reported a non-empty heap")

endmodule

@@ tb/binary_min_heap_queue_tb.sv @@
// Self-checking testbench for the binary min-heap queue with its own heap predictor
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;
    import bmhq_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int PAYLOAD_BITS = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 80;

    typedef struct {
        logic [DATA_W-1:0]  payload;
        prio_t              prio;
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } heap_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic                     req_type;
    logic signed [PRIO_W-1:0] priority_req;
    logic [DATA_W-1:0]        payload;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [DATA_W-1:0]        popped_payload;
    logic signed [PRIO_W-1:0] popped_priority;
    status_t                  status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;

    prio_t             store_prio [CAPACITY];
    logic [DATA_W-1:0] store_data [CAPACITY];
    int                heap_fill;

    heap_result_t pending_outcomes[$];
    int           mismatch_count;
    int           cycle_count;
    int           req_idle_mode;
    int           rsp_idle_mode;
    int           hold_off_cycles;
    int           stall_left;

    binary_min_heap_queue #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_type        (req_type),
        .priority_req    (priority_req),
        .payload         (payload),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .popped_payload  (popped_payload),
        .popped_priority (popped_priority),
        .status          (status),
        .entry_count     (entry_count),
        .is_empty        (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void swap_entries(int a, int b);
        prio_t             p;
        logic [DATA_W-1:0] d;
        p = store_prio[a];
        d = store_data[a];
        store_prio[a] = store_prio[b];
        store_data[a] = store_data[b];
        store_prio[b] = p;
        store_data[b] = d;
    endfunction

    function automatic heap_result_t apply_to_heap(logic op, prio_t prio,
                                                   logic [DATA_W-1:0] data);
        heap_result_t r;
        int           pos;
        int           up;
        int           lt;
        int           rt;
        int           pick;
        bit           done;
        r.payload = '0;
        r.prio    = '0;
        r.status  = ST_OK;
        done      = 1'b0;
        if (op == REQ_PUSH)
        begin
            if (heap_fill >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                store_prio[heap_fill] = prio;
                store_data[heap_fill] = data;
                heap_fill++;
                pos = heap_fill - 1;
                while (pos != 0 && !done)
                begin
                    up = (pos - 1) / 2;
                    if ($signed(store_prio[up]) > $signed(store_prio[pos]))
                    begin
                        swap_entries(up, pos);
                        pos = up;
                    end
                    else
                        done = 1'b1;
                end
            end
        end
        else
        begin
            if (heap_fill == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.payload = store_data[0];
                r.prio    = store_prio[0];
                heap_fill--;
                store_prio[0] = store_prio[heap_fill];
                store_data[0] = store_data[heap_fill];
                pos = 0;
                while (!done)
                begin
                    lt = 2 * pos + 1;
                    rt = lt + 1;
                    if (lt >= heap_fill)
                        done = 1'b1;
                    else
                    begin
                        pick = lt;
                        if (rt < heap_fill &&
                            $signed(store_prio[rt]) <= $signed(store_prio[lt]))
                            pick = rt;
                        if ($signed(store_prio[pick]) <= $signed(store_prio[pos]))
                        begin
                            swap_entries(pick, pos);
                            pos = pick;
                        end
                        else
                            done = 1'b1;
                    end
                end
            end
        end
        r.count = COUNT_W'(heap_fill);
        r.empty = (heap_fill == 0);
        return r;
    endfunction

    function automatic int pick_gap(int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic prio_t pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return prio_t'($urandom);
            4, 5, 6:    return prio_t'($urandom_range(0, 16) - 8);
            7:          return 32'h7fff_ffff;
            8:          return 32'h8000_0000;
            default:    return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
        endcase
    endfunction

    task automatic send_request(logic op, prio_t prio, logic [DATA_W-1:0] data);
        int gap;
        gap = pick_gap(req_idle_mode);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid    <= 1'b1;
        req_type     <= op;
        priority_req <= prio;
        payload      <= data;
        do
            @(posedge clk);
        while (req_stall);
        pending_outcomes.push_back(apply_to_heap(op, prio, data));
    endtask

    task automatic send_random(int pop_percent);
        if ($urandom_range(0, 99) < pop_percent)
            send_request(REQ_POP, prio_t'($urandom), $urandom);
        else
            send_request(REQ_PUSH, pick_priority(), $urandom);
    endtask

    task automatic shuffle_idle_modes();
        req_idle_mode = $urandom_range(0, 1);
        rsp_idle_mode = $urandom_range(0, 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        heap_result_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual payload %h",
                         $time, popped_payload);
                mismatch_count++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                check_field("popped_payload", e.payload, popped_payload);
                check_field("popped_priority", e.prio, popped_priority);
                check_field("status", 32'(e.status), 32'(status));
                check_field("entry_count", 32'(e.count), 32'(entry_count));
                check_field("is_empty", 32'(e.empty), 32'(is_empty));
            end
        end
    end

    initial
    begin
        rsp_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                hold_off_cycles--;
            end
            else if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left = pick_gap(rsp_idle_mode);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic test_pop_on_empty();
        send_request(REQ_POP, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_PUSH, 32'h0000_0005, 32'hdead_beef);
        send_request(REQ_POP, 32'hffff_ffff, 32'hffff_ffff);
        send_request(REQ_POP, 32'h1234_5678, 32'h8765_4321);
    endtask

    task automatic test_field_extremes();
        send_request(REQ_PUSH, 32'h7fff_ffff, 32'hffff_ffff);
        send_request(REQ_PUSH, 32'h8000_0000, 32'h0000_0000);
        send_request(REQ_PUSH, 32'h0000_0000, 32'haaaa_aaaa);
        send_request(REQ_PUSH, 32'hffff_ffff, 32'h5555_5555);
        send_request(REQ_PUSH, 32'h0000_0001, 32'h0000_0001);
        send_request(REQ_PUSH, 32'h8000_0001, 32'h8000_0000);
        send_request(REQ_PUSH, 32'h7fff_fffe, 32'h7fff_ffff);
        repeat (8)
            send_request(REQ_POP, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_equal_priorities();
        for (int i = 0; i < 6; i++)
            send_request(REQ_PUSH, 32'h0000_0003, 32'h1000_0000 + i);
        repeat (7)
            send_request(REQ_POP, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 60; i++)
        begin
            if (i % 16 == 0)
                shuffle_idle_modes();
            send_random(45);
        end
    endtask

    task automatic test_result_backpressure();
        req_idle_mode   = 0;
        hold_off_cycles = 150;
        repeat (12)
            send_request(REQ_PUSH, pick_priority(), $urandom);
        wait_drained();
    endtask

    task automatic test_fill_to_capacity();
        int n;
        n = 0;
        while (heap_fill < CAPACITY)
        begin
            if (n % 64 == 0)
                shuffle_idle_modes();
            send_random(3);
            n++;
        end
        repeat (4)
            send_request(REQ_PUSH, pick_priority(), $urandom);
    endtask

    task automatic test_drain_mix();
        for (int i = 0; i < 100; i++)
        begin
            if (i % 32 == 0)
                shuffle_idle_modes();
            send_random(70);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req_type        = REQ_PUSH;
        priority_req    = '0;
        payload         = '0;
        heap_fill       = 0;
        mismatch_count  = 0;
        hold_off_cycles = 0;
        req_idle_mode   = 0;
        rsp_idle_mode   = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;

        test_pop_on_empty();
        req_idle_mode = 1;
        rsp_idle_mode = 1;
        test_field_extremes();
        test_equal_priorities();
        wait_drained();
        test_random_mix();
        test_result_backpressure();
        test_fill_to_capacity();
        test_drain_mix();

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
